>>> hdl/crcfb_pkg.sv
// Package with the shared constants, types and CRC function of the CRC-16 frame builder.
package crcfb_pkg;

  localparam int FRAME_SIZE_DEF = 34;

  localparam logic [7:0]  HDR_FIRST  = 8'hD5;
  localparam logic [7:0]  HDR_SECOND = 8'h5A;
  localparam logic [15:0] CRC_POLY   = 16'h1021;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;

  // Folds one byte into a CRC-16-CCITT, MSB first.
  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  // CRC after both header bytes; every frame starts from this value.
  localparam logic [15:0] HDR_CRC = crc_fold(crc_fold(CRC_INIT, HDR_FIRST), HDR_SECOND);

  // Everything one request produces on the frame side.
  typedef struct packed {
    logic        hdr;    // header bytes go out before the payload byte
    logic [7:0]  data;   // the payload byte
    logic        close;  // CRC bytes follow and end the frame
    logic [15:0] crc;    // CRC including this payload byte
  } grp_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HDR1,
    PH_HDR2,
    PH_DATA,
    PH_CRC_HI,
    PH_CRC_LO
  } phase_t;

endpackage

>>> hdl/crcfb_if.sv
// Valid/ready channel interfaces for payload bytes in and frame bytes out.
interface crcfb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;

  modport source (output valid, output payload_byte, input ready);
  modport sink (input valid, input payload_byte, output ready);
endinterface

interface crcfb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       frame_end;

  modport source (output valid, output out_byte, output frame_end, input ready);
  modport sink (input valid, input out_byte, input frame_end, output ready);
endinterface

>>> hdl/crcfb_core.sv
// Frame position and running CRC; forms the byte group for each accepted payload byte.
module crcfb_core import crcfb_pkg::*; #(
  parameter int FRAME_SIZE = FRAME_SIZE_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] payload_byte,
  output grp_t       grp
);

  localparam int EffSize = (FRAME_SIZE < 6) ? 6 : ((FRAME_SIZE > 256) ? 256 : FRAME_SIZE);
  localparam int LastPos = EffSize - 5;
  localparam int PosW    = (LastPos < 2) ? 1 : $clog2(LastPos + 1);

  logic [PosW-1:0] pos;
  logic [PosW-1:0] pos_next;
  logic [15:0]     crc;
  logic [15:0]     crc_next;
  logic [15:0]     crc_base;
  logic            first;
  logic            close;

  assign first    = (pos == '0);
  assign close    = (pos >= PosW'(LastPos));
  assign crc_base = first ? HDR_CRC : crc;

  always_comb begin
    grp.hdr   = first;
    grp.data  = payload_byte;
    grp.close = close;
    grp.crc   = crc_fold(crc_base, payload_byte);
  end

  assign pos_next = close ? '0 : pos + PosW'(1);
  assign crc_next = close ? CRC_INIT : grp.crc;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      crc <= CRC_INIT;
    end else if (accept) begin
      pos <= pos_next;
      crc <= crc_next;
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (rst) pos <= PosW'(LastPos))
    else $error("frame position beyond last payload slot");
  a_close_restart: assert property (@(posedge clk) disable iff (rst)
    (accept && close) |=> (pos == '0 && crc == CRC_INIT))
    else $error("frame did not restart after closing");

endmodule

>>> hdl/crcfb_serializer.sv
// Holds one byte group and sends its header, payload and CRC bytes one per cycle while the receiver is ready.
module crcfb_serializer import crcfb_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  grp_t  grp_in,
  crcfb_out_if.source frame
);

  phase_t phase;
  phase_t phase_next;
  grp_t   grp;
  logic   last;
  logic   load;
  logic   taken;

  assign last  = (phase == PH_DATA && !grp.close) || (phase == PH_CRC_LO);
  assign taken = frame.valid && frame.ready;
  assign in_ready = (phase == PH_IDLE) || (last && frame.ready);
  assign load  = in_valid && in_ready;

  always_comb begin
    phase_next = phase;
    if (load) begin
      phase_next = grp_in.hdr ? PH_HDR1 : PH_DATA;
    end else if (taken) begin
      case (phase)
        PH_HDR1:   phase_next = PH_HDR2;
        PH_HDR2:   phase_next = PH_DATA;
        PH_DATA:   phase_next = grp.close ? PH_CRC_HI : PH_IDLE;
        PH_CRC_HI: phase_next = PH_CRC_LO;
        PH_CRC_LO: phase_next = PH_IDLE;
        default:   phase_next = PH_IDLE;
      endcase
    end
  end

  always_comb begin
    frame.valid     = (phase != PH_IDLE);
    frame.frame_end = (phase == PH_CRC_LO);
    case (phase)
      PH_HDR1:   frame.out_byte = HDR_FIRST;
      PH_HDR2:   frame.out_byte = HDR_SECOND;
      PH_CRC_HI: frame.out_byte = grp.crc[15:8];
      PH_CRC_LO: frame.out_byte = grp.crc[7:0];
      default:   frame.out_byte = grp.data;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      grp <= grp_in;
    end
  end

  a_crc_pair: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_CRC_HI && taken) |=> (phase == PH_CRC_LO))
    else $error("CRC high byte not followed by low byte");
  a_hdr_pair: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_HDR1 && taken) |=> (phase == PH_HDR2 && frame.valid))
    else $error("header bytes split");

endmodule

>>> hdl/crc16_frame_builder.sv
// Top level of the CRC-16 frame builder: payload bytes in, framed bytes out.
//
//  Channel   Dir  Fields                  Role
//  payload   in   payload_byte[7:0]       one payload byte per request
//  frame     out  out_byte[7:0], frame_end header, payload or CRC byte; frame_end on last
//
// Each payload byte yields one output byte in mid-frame, three at frame start
// (0xD5, 0x5A, payload) and three at frame end (payload, CRC high, CRC low).
// In mid-frame one request is taken per cycle while the receiver is ready; the byte
// group register frees up in the same cycle its last byte is taken, so the only
// bubbles are for the header bytes at frame start and the CRC bytes at frame end.
// Reset (rst, synchronous) clears the frame position and loads the CRC seed;
// no output is pending after reset. Output stalls hold the group register and
// hold off new payload requests; input bubbles simply leave the output idle.
module crc16_frame_builder import crcfb_pkg::*; #(
  parameter int FRAME_SIZE = FRAME_SIZE_DEF
) (
  input logic clk,
  input logic rst,
  crcfb_in_if.sink    payload,
  crcfb_out_if.source frame
);

  grp_t grp;
  logic in_ready;
  logic accept;

  // A payload request is taken when the serializer can load a new byte group.
  assign payload.ready = in_ready;
  assign accept        = payload.valid && in_ready;

  // Position and CRC tracking; the group for this byte is formed combinationally.
  crcfb_core #(
    .FRAME_SIZE(FRAME_SIZE)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .payload_byte(payload.payload_byte),
    .grp         (grp)
  );

  // Registered byte group, sent out one byte per cycle while the receiver is ready.
  crcfb_serializer u_ser (
    .clk     (clk),
    .rst     (rst),
    .in_valid(payload.valid),
    .in_ready(in_ready),
    .grp_in  (grp),
    .frame   (frame)
  );

endmodule

>>> sim/crcfb_frame_checker.sv
// Checker for the frame builder: watches both channels, predicts frame bytes and compares.
module crcfb_frame_checker import crcfb_pkg::*; #(
  parameter int FRAME_SIZE = FRAME_SIZE_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_byte,
  input  logic       out_end,
  output int         errors,
  output int         pending
);

  // Frame sizes outside the supported span are clamped.
  localparam int EFF_SIZE = (FRAME_SIZE < 6) ? 6 : ((FRAME_SIZE > 256) ? 256 : FRAME_SIZE);
  localparam int LAST_POS = EFF_SIZE - 5;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_byte_t;

  frame_byte_t  frame_q[$];
  logic [7:0]   payload_pos;
  logic [15:0]  crc_acc;
  int           err_n = 0;

  // Bitwise CRC-16-CCITT update, one data bit per step, MSB first.
  function automatic logic [15:0] crc16_next(input logic [15:0] c, input logic [7:0] d);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ d[i];
      c  = {c[14:0], 1'b0};
      if (fb) c = c ^ CRC_POLY;
    end
    return c;
  endfunction

  task automatic queue_frame_bytes(input logic [7:0] b);
    logic [15:0] c;
    c = crc_acc;
    if (payload_pos == 8'd0) begin
      c = CRC_INIT;
      frame_q.push_back('{HDR_FIRST, 1'b0});
      c = crc16_next(c, HDR_FIRST);
      frame_q.push_back('{HDR_SECOND, 1'b0});
      c = crc16_next(c, HDR_SECOND);
    end
    frame_q.push_back('{b, 1'b0});
    c = crc16_next(c, b);
    if (int'(payload_pos) >= LAST_POS) begin
      frame_q.push_back('{c[15:8], 1'b0});
      frame_q.push_back('{c[7:0], 1'b1});
      payload_pos = 8'd0;
      crc_acc     = CRC_INIT;
    end else begin
      payload_pos = payload_pos + 8'd1;
      crc_acc     = c;
    end
  endtask

  always @(posedge clk) begin
    frame_byte_t want;
    if (rst) begin
      frame_q.delete();
      payload_pos = 8'd0;
      crc_acc     = CRC_INIT;
    end else begin
      if (in_valid && in_ready) queue_frame_bytes(in_byte);
      if (out_valid && out_ready) begin
        if (frame_q.size() == 0) begin
          if (err_n < 10)
            $display("unexpected frame byte %02h end %0b at %0t", out_byte, out_end, $realtime);
          err_n++;
        end else begin
          want = frame_q.pop_front();
          if (out_byte !== want.data || out_end !== want.last) begin
            if (err_n < 10)
              $display("mismatch at %0t: expected byte %02h end %0b, got byte %02h end %0b",
                       $realtime, want.data, want.last, out_byte, out_end);
            err_n++;
          end
        end
      end
    end
    errors  <= err_n;
    pending <= frame_q.size();
  end

endmodule

>>> sim/tb_crc16_frame_builder.sv
// Testbench top for the CRC-16 frame builder: stimulus, receiver stalls, watchdog and verdict.
module tb_crc16_frame_builder;
  import crcfb_pkg::*;

  localparam int FRAME_SIZE  = FRAME_SIZE_DEF;
  // Longest stretch without any request on either channel before the run is
  // declared hung. The deliberate receiver hold-off is far shorter than this.
  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;
  localparam int RAND_ITEMS  = 27;

  // One full frame of directed payload: both extremes at the frame edges,
  // walking ones and zeros, and alternating patterns in between.
  localparam logic [7:0] DIRECTED [30] = '{
    8'hFF, 8'h00, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80,
    8'hFE, 8'hFD, 8'hFB, 8'hF7, 8'hEF, 8'hDF, 8'hBF, 8'h7F, 8'h55, 8'hAA,
    8'h0F, 8'hF0, 8'h33, 8'hCC, 8'h5A, 8'hD5, 8'h12, 8'h34, 8'h00, 8'hFF
  };

  logic clk;
  logic rst;

  crcfb_in_if  pay_ch ();
  crcfb_out_if frm_ch ();

  int chk_errors;
  int chk_pending;

  // Percent chance per cycle that the sender or the receiver sits idle.
  int   send_idle = 26;
  int   recv_idle = 82;
  // Set by the stimulus to ask the receiver for one long hold-off.
  logic hold_req  = 1'b0;

  crc16_frame_builder #(.FRAME_SIZE(FRAME_SIZE)) dut (
    .clk     (clk),
    .rst     (rst),
    .payload (pay_ch),
    .frame   (frm_ch)
  );

  crcfb_frame_checker #(.FRAME_SIZE(FRAME_SIZE)) chk (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pay_ch.valid),
    .in_ready  (pay_ch.ready),
    .in_byte   (pay_ch.payload_byte),
    .out_valid (frm_ch.valid),
    .out_ready (frm_ch.ready),
    .out_byte  (frm_ch.out_byte),
    .out_end   (frm_ch.frame_end),
    .errors    (chk_errors),
    .pending   (chk_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offers one payload byte and returns at the edge where the request is taken.
  // Valid is dropped only when an idle cycle is inserted, so back-to-back
  // requests keep valid high without a low/high pair in the same step.
  task automatic send_payload(input logic [7:0] b);
    while ($urandom_range(99) < send_idle) begin
      pay_ch.valid <= 1'b0;
      @(posedge clk);
    end
    pay_ch.valid        <= 1'b1;
    pay_ch.payload_byte <= b;
    do @(posedge clk); while (!pay_ch.ready);
  endtask

  // Sender pause: stop offering and wait until every predicted frame byte has
  // been taken. The first edge lets the checker count the last request.
  task automatic drain_frames();
    pay_ch.valid <= 1'b0;
    @(posedge clk);
    while (chk_pending != 0) @(posedge clk);
  endtask

  // Receiver side. Ready is redrawn every cycle from the current idle rate;
  // on a hold request it stays low for a long counted stretch so that the
  // builder backs up and refuses new payload requests.
  initial begin
    frm_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        frm_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        frm_ch.ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  // Watchdog: counts consecutive cycles in which no request moves on either
  // channel and ends the run if the block stops making progress.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((pay_ch.valid && pay_ch.ready) || (frm_ch.valid && frm_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    rst                 = 1'b1;
    pay_ch.valid        = 1'b0;
    pay_ch.payload_byte = 8'h00;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed frame: header emission on the first byte, CRC close on the
    // last, with the slow receiver so stalls can land on any byte of a group.
    foreach (DIRECTED[i]) send_payload(DIRECTED[i]);
    drain_frames();

    // Phase one: slow receiver, with a long hold-off at the start.
    hold_req = 1'b1;
    repeat (RAND_ITEMS) send_payload(8'($urandom_range(255)));
    drain_frames();

    // Phase two: the roles swap, the sender is the slow side.
    send_idle = 82;
    recv_idle = 26;
    repeat (RAND_ITEMS) send_payload(8'($urandom_range(255)));
    drain_frames();

    // Phase three: full rate on both sides, and another hold-off so that a
    // steady stream of requests runs into a full builder.
    send_idle = 0;
    recv_idle = 0;
    hold_req  = 1'b1;
    repeat (RAND_ITEMS) send_payload(8'($urandom_range(255)));
    drain_frames();

    // Let any late byte show up before the verdict.
    repeat (20) @(posedge clk);
    if (chk_errors == 0 && chk_pending == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
